// ----- hw/rtl/tgb_pkg.sv -----
// Shared constants, types and a helper function of the text glyph blitter.
`timescale 1ns / 1ps
`default_nettype none

package tgb_pkg;

  localparam int GLYPH_COUNT  = 256;
  localparam int GLYPH_WIDTH  = 3;
  localparam int GLYPH_HEIGHT = 8;
  localparam int LINE_PITCH   = 256;

  localparam int GLYPH_WORDS  = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_WORDS;

  localparam int FONT_AW = $clog2(STORE_DEPTH);
  localparam int ADDR_W  = 17;
  localparam int PIX_W   = 16;
  localparam int PX_W    = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int PY_W    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PIX_W-1:0] PIX_SET_BIT = 16'h8000;
  localparam logic [PIX_W-1:0] RED_MASK    = 16'h001f;
  localparam logic [PIX_W-1:0] GREEN_MASK  = 16'h03e0;
  localparam logic [PIX_W-1:0] BLUE_MASK   = 16'h7c00;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DRAW   = 2'd1,
    OP_COLOUR = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // register select: paddr bit 2
  localparam logic REG_TOP_FONT_RGB    = 1'b0;
  localparam logic REG_BOTTOM_FONT_RGB = 1'b1;

  localparam logic [PIX_W-1:0] PALETTE [16] = '{
    {1'b0, 5'd0,  5'd0,  5'd0 }, {1'b0, 5'd9,  5'd9,  5'd15},
    {1'b0, 5'd9,  5'd15, 5'd9 }, {1'b0, 5'd9,  5'd15, 5'd15},
    {1'b0, 5'd15, 5'd9,  5'd9 }, {1'b0, 5'd15, 5'd9,  5'd15},
    {1'b0, 5'd15, 5'd15, 5'd9 }, {1'b0, 5'd23, 5'd23, 5'd23},
    {1'b0, 5'd15, 5'd15, 5'd15}, {1'b0, 5'd15, 5'd15, 5'd31},
    {1'b0, 5'd15, 5'd31, 5'd15}, {1'b0, 5'd15, 5'd31, 5'd31},
    {1'b0, 5'd31, 5'd15, 5'd15}, {1'b0, 5'd31, 5'd15, 5'd31},
    {1'b0, 5'd31, 5'd31, 5'd15}, {1'b0, 5'd31, 5'd31, 5'd31}
  };

  function automatic logic [PIX_W-1:0] swap_red_blue(input logic [PIX_W-1:0] w);
    swap_red_blue = (w & PIX_SET_BIT) | ((w & RED_MASK) << 10) | (w & GREEN_MASK) |
                    ((w & BLUE_MASK) >> 10);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/text_glyph_blitter.sv -----
// Top level of the text glyph blitter: sequencer, font memory and pixel pipeline.
//
// Usage: a request is accepted on a rising edge with start high and busy low.
// Op 0 writes one font word (indexes at or beyond the store depth are dropped),
// op 3 does nothing, and neither makes the block busy. Ops 1 and 2 draw one
// glyph: the sequencer issues one font memory read per cycle, and busy stays
// high until the cycle that issues the last read, so glyphs stream back to back.
// Each pixel leaves through three register stages (sequencer, memory read data,
// colour stage); pixels follow one per cycle on the result ports, and last_o
// marks the 24th. pixel_strobe_o is high for exactly one cycle per pixel; the
// receiver cannot stall, so there is no backpressure.
// Reset clears the sequencer and the valid bits and sets top_font_rgb to 1 and
// bottom_font_rgb to 0; the font memory is not cleared and must be loaded
// before glyphs are drawn. Configuration goes through the APB port (top screen
// at 0x0, bottom screen at 0x4); the user must write it only while the block is
// idle, and the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module text_glyph_blitter
  import tgb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [1:0]          op_i,
  input  wire logic [12:0]         font_index_i,
  input  wire logic [15:0]         font_word_i,
  input  wire logic [7:0]          column_i,
  input  wire logic [5:0]          row_i,
  input  wire logic [7:0]          glyph_i,
  input  wire logic [7:0]          colour_i,
  output      logic                pixel_strobe_o,
  output      logic                screen_o,
  output      logic [ADDR_W-1:0]   pixel_address_o,
  output      logic [PIX_W-1:0]    pixel_value_o,
  output      logic                last_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output      logic [PDATA_W-1:0]  prdata,
  output      logic                pready
);

  op_e               op;
  logic              accept, draw, load_wr, issue_last, cfg_wr;

  logic              top_rgb_q, bottom_rgb_q;

  logic              busy_q, busy_d;
  logic [PX_W-1:0]   px_q, px_d;
  logic [PY_W-1:0]   py_q, py_d;
  logic [FONT_AW-1:0] rd_idx_q;
  logic [ADDR_W-1:0] base_q;
  logic              screen_q, colour_mode_q, swap_q;
  logic [PIX_W-1:0]  fg_q, bg_q;
  logic [ADDR_W-1:0] issue_addr;

  logic [PIX_W-1:0]  font_mem_q [STORE_DEPTH];

  logic              s1_valid_q, s1_screen_q, s1_last_q, s1_colour_mode_q, s1_swap_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [PIX_W-1:0]  s1_rdata_q, s1_fg_q, s1_bg_q;
  logic [PIX_W-1:0]  s1_font, s1_pix;

  logic              s2_valid_q, s2_screen_q, s2_last_q;
  logic [ADDR_W-1:0] s2_addr_q;
  logic [PIX_W-1:0]  s2_pix_q;

  assign op         = op_e'(op_i);
  assign issue_last = busy_q && (px_q == PX_W'(GLYPH_WIDTH - 1)) &&
                      (py_q == PY_W'(GLYPH_HEIGHT - 1));
  assign busy       = busy_q && !issue_last;
  assign accept     = start && !busy;
  assign draw       = accept && ((op == OP_DRAW) || (op == OP_COLOUR));
  assign load_wr    = accept && (op == OP_LOAD) && (font_index_i < FONT_AW'(STORE_DEPTH));

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_TOP_FONT_RGB:    prdata[0] = top_rgb_q;
      REG_BOTTOM_FONT_RGB: prdata[0] = bottom_rgb_q;
      default:             prdata    = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_rgb_q    <= 1'b1;
      bottom_rgb_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TOP_FONT_RGB:    top_rgb_q    <= pwdata[0];
        REG_BOTTOM_FONT_RGB: bottom_rgb_q <= pwdata[0];
        default:             top_rgb_q    <= top_rgb_q;
      endcase
    end
  end

  // sequencer
  always_comb begin
    busy_d = busy_q;
    px_d   = px_q;
    py_d   = py_q;
    if (draw) begin
      busy_d = 1'b1;
      px_d   = '0;
      py_d   = '0;
    end else if (busy_q) begin
      if (issue_last) begin
        busy_d = 1'b0;
      end
      if (px_q == PX_W'(GLYPH_WIDTH - 1)) begin
        px_d = '0;
        py_d = py_q + 1'b1;
      end else begin
        px_d = px_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      px_q   <= '0;
      py_q   <= '0;
    end else begin
      busy_q <= busy_d;
      px_q   <= px_d;
      py_q   <= py_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      rd_idx_q      <= FONT_AW'(glyph_i) * FONT_AW'(GLYPH_WORDS);
      base_q        <= ADDR_W'(row_i[4:0]) * ADDR_W'(GLYPH_HEIGHT * LINE_PITCH) +
                       ADDR_W'(column_i) * ADDR_W'(GLYPH_WIDTH);
      screen_q      <= row_i[5];
      swap_q        <= row_i[5] ? bottom_rgb_q : top_rgb_q;
      colour_mode_q <= (op == OP_COLOUR);
      fg_q          <= PALETTE[colour_i[3:0]];
      bg_q          <= PALETTE[colour_i[7:4]];
    end else if (busy_q) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  assign issue_addr = base_q + ADDR_W'(py_q) * ADDR_W'(LINE_PITCH) + ADDR_W'(px_q);

  // font memory
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      font_mem_q[font_index_i] <= font_word_i;
    end
    if (busy_q) begin
      s1_rdata_q <= font_mem_q[rd_idx_q];
    end
  end

  // stage 1: read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      s1_screen_q      <= screen_q;
      s1_addr_q        <= issue_addr;
      s1_last_q        <= issue_last;
      s1_colour_mode_q <= colour_mode_q;
      s1_swap_q        <= swap_q;
      s1_fg_q          <= fg_q;
      s1_bg_q          <= bg_q;
    end
  end

  // stage 2: colour
  always_comb begin
    s1_font = s1_swap_q ? swap_red_blue(s1_rdata_q) : s1_rdata_q;
    if (s1_colour_mode_q) begin
      s1_pix = (s1_font & s1_fg_q) | (~s1_font & s1_bg_q) | PIX_SET_BIT;
    end else begin
      s1_pix = s1_font | PIX_SET_BIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_screen_q <= s1_screen_q;
      s2_addr_q   <= s1_addr_q;
      s2_pix_q    <= s1_pix;
      s2_last_q   <= s1_last_q;
    end
  end

  assign pixel_strobe_o  = s2_valid_q;
  assign screen_o        = s2_screen_q;
  assign pixel_address_o = s2_addr_q;
  assign pixel_value_o   = s2_pix_q;
  assign last_o          = s2_valid_q && s2_last_q;

`ifndef SYNTH
  a_last_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |=> (pixel_strobe_o && last_o))
    else $error("last pixel of a glyph lost in the pipeline");

  a_glyph_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_last_q) |-> s1_valid_q)
    else $error("gap inside a glyph's pixel stream");

  a_draw_starts_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw |=> (busy_q && (px_q == '0) && (py_q == '0)))
    else $error("draw request did not start the sequencer at the first pixel");
`endif

endmodule

`default_nettype wire
